@@ sv/i2cmts_pkg.sv @@
// Shared types, codes and helpers for the I2C master transaction sequencer.
// No dependencies; compiled first.
package i2cmts_pkg;

    localparam int BUFFER_DEPTH = 256;
    localparam int BUF_AW       = $clog2(BUFFER_DEPTH);

    // event codes
    localparam logic [2:0] FN_LOAD  = 3'd0;
    localparam logic [2:0] FN_START = 3'd1;
    localparam logic [2:0] FN_COND  = 3'd2;
    localparam logic [2:0] FN_ACK   = 3'd3;
    localparam logic [2:0] FN_RX    = 3'd4;

    // transfer modes
    localparam logic [1:0] MODE_READ    = 2'd0;
    localparam logic [1:0] MODE_WRITE   = 2'd1;
    localparam logic [1:0] MODE_REGREAD = 2'd2;

    // bus commands
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_RESTART = 3'd2;
    localparam logic [2:0] CMD_STOP    = 3'd3;
    localparam logic [2:0] CMD_RELEASE = 3'd4;
    localparam logic [2:0] CMD_DATA    = 3'd5;

    // ack and receive-enable controls
    localparam logic [1:0] ACK_SEND   = 2'd1;
    localparam logic [1:0] ACK_NACK   = 2'd2;
    localparam logic [1:0] RX_ENABLE  = 2'd1;
    localparam logic [1:0] RX_DISABLE = 2'd2;

    localparam logic [7:0] READ_BIT   = 8'h01;
    localparam logic [7:0] DUMMY_BYTE = 8'hFF;

    typedef logic [BUF_AW-1:0] buf_ptr_t;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] slave_addr;
        logic [1:0] xfer_mode;
        logic [7:0] count;
        logic [7:0] read_count;
        logic [7:0] data_byte;
        logic       nack;
    } in_item_t;

    typedef struct packed {
        logic [2:0] bus_cmd;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [1:0] ack_ctl;
        logic [1:0] rx_irq_ctl;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [7:0] rx_index;
        logic       done_res;
        logic       nack_seen;
        logic       busy_res;
    } out_item_t;

    // write buffer port requests from the core
    typedef struct packed {
        logic       we;
        buf_ptr_t   waddr;
        logic [7:0] wdata;
        buf_ptr_t   raddr;
    } buf_req_t;

    function automatic buf_ptr_t ptr_inc(input buf_ptr_t p);
        buf_ptr_t r;
        r = (p == BUF_AW'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

endpackage

@@ sv/i2cmts_in_if.sv @@
// Event input channel: valid/ready handshake with an event payload.
// Depends on i2cmts_pkg.
interface i2cmts_in_if;
    import i2cmts_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

@@ sv/i2cmts_out_if.sv @@
// Result output channel: valid/ready handshake with a result payload.
// Depends on i2cmts_pkg.
interface i2cmts_out_if;
    import i2cmts_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

@@ sv/i2cmts_buf.sv @@
// Write byte buffer: one write port, one read port with registered data.
// Depends on i2cmts_pkg.
module i2cmts_buf (
    input  logic                  clk,
    input  i2cmts_pkg::buf_req_t  req,
    output logic [7:0]            rd_data
);
    import i2cmts_pkg::*;

    logic [7:0] mem [BUFFER_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/i2cmts_core.sv @@
// Sequencer state and the per-event decision logic producing one result.
// Depends on i2cmts_pkg; drives the write buffer in i2cmts_buf.
module i2cmts_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  i2cmts_pkg::in_item_t   item,
    input  logic [7:0]             buf_rd_data,
    output i2cmts_pkg::buf_req_t   buf_req,
    output i2cmts_pkg::out_item_t  result
);
    import i2cmts_pkg::*;

    typedef enum logic [1:0] {PH_ADDR, PH_STOP, PH_RESTART, PH_DATA} phase_t;

    phase_t     phase_reg,   phase_next;
    logic [1:0] dir_reg,     dir_next;
    logic [7:0] remain_reg,  remain_next;
    logic [7:0] pend_reg,    pend_next;
    logic [7:0] target_reg,  target_next;
    buf_ptr_t   rd_ptr_reg,  rd_ptr_next;
    buf_ptr_t   wr_ptr_reg,  wr_ptr_next;
    logic [7:0] rx_cnt_reg,  rx_cnt_next;
    logic       busy_reg,    busy_next;
    out_item_t  res;
    logic       mode_ok;

    assign mode_ok = (item.xfer_mode == MODE_READ) || (item.xfer_mode == MODE_WRITE)
                     || (item.xfer_mode == MODE_REGREAD);

    always_comb
    begin
        phase_next  = phase_reg;
        dir_next    = dir_reg;
        remain_next = remain_reg;
        pend_next   = pend_reg;
        target_next = target_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        rx_cnt_next = rx_cnt_reg;
        busy_next   = busy_reg;
        res         = '0;
        res.bus_cmd = CMD_NONE;

        case (item.func)
            FN_LOAD:
            begin
                if (!busy_reg)
                begin
                    wr_ptr_next = ptr_inc(wr_ptr_reg);
                end
            end
            FN_START:
            begin
                if (!busy_reg && mode_ok)
                begin
                    dir_next    = item.xfer_mode;
                    rd_ptr_next = '0;
                    wr_ptr_next = '0;
                    rx_cnt_next = '0;
                    phase_next  = PH_ADDR;
                    busy_next   = 1'b1;
                    res.bus_cmd = CMD_START;
                    if (item.xfer_mode == MODE_WRITE)
                    begin
                        target_next = item.slave_addr;
                        remain_next = item.count;
                    end
                    else if (item.xfer_mode == MODE_READ)
                    begin
                        target_next    = item.slave_addr | READ_BIT;
                        remain_next    = item.count;
                        res.rx_irq_ctl = RX_DISABLE;
                    end
                    else
                    begin
                        target_next    = item.slave_addr;
                        remain_next    = 8'd1;
                        pend_next      = item.read_count;
                        res.rx_irq_ctl = RX_DISABLE;
                    end
                end
            end
            FN_COND:
            begin
                if (busy_reg)
                begin
                    case (phase_reg)
                        PH_ADDR:
                        begin
                            res.ack_ctl  = ACK_NACK;
                            res.tx_valid = 1'b1;
                            res.tx_byte  = target_reg;
                            res.bus_cmd  = CMD_DATA;
                        end
                        PH_STOP:
                        begin
                            phase_next   = PH_ADDR;
                            busy_next    = 1'b0;
                            res.bus_cmd  = CMD_RELEASE;
                            res.done_res = 1'b1;
                        end
                        PH_RESTART:
                        begin
                            remain_next  = pend_reg;
                            rx_cnt_next  = '0;
                            dir_next     = MODE_READ;
                            phase_next   = PH_ADDR;
                            res.ack_ctl  = ACK_NACK;
                            res.tx_valid = 1'b1;
                            res.tx_byte  = target_reg | READ_BIT;
                            res.bus_cmd  = CMD_DATA;
                        end
                        default: ;
                    endcase
                end
            end
            FN_ACK:
            begin
                if (busy_reg)
                begin
                    // end of count: stop, restart, or final NACK on reads
                    if (remain_reg <= 8'd1)
                    begin
                        if (remain_reg == 8'd0 && dir_reg != MODE_READ)
                        begin
                            if (dir_reg == MODE_WRITE)
                            begin
                                phase_next  = PH_STOP;
                                res.bus_cmd = CMD_STOP;
                            end
                            else
                            begin
                                phase_next  = PH_RESTART;
                                res.bus_cmd = CMD_RESTART;
                            end
                        end
                        else if (dir_reg == MODE_READ)
                        begin
                            if (remain_reg != 8'd0)
                            begin
                                res.ack_ctl = ACK_NACK;
                            end
                            else
                            begin
                                res.rx_irq_ctl = RX_DISABLE;
                                phase_next     = PH_STOP;
                                res.bus_cmd    = CMD_STOP;
                            end
                        end
                    end
                    if (!item.nack && phase_next == PH_ADDR)
                    begin
                        phase_next = PH_DATA;
                        if (dir_reg != MODE_READ)
                        begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = buf_rd_data;
                            rd_ptr_next  = ptr_inc(rd_ptr_reg);
                            remain_next  = remain_reg - 8'd1;
                        end
                        else
                        begin
                            if (remain_reg >= 8'd2)
                            begin
                                res.ack_ctl = ACK_SEND;
                            end
                            res.rx_irq_ctl = RX_ENABLE;
                            res.tx_valid   = 1'b1;
                            res.tx_byte    = DUMMY_BYTE;
                        end
                        res.bus_cmd = CMD_DATA;
                    end
                    else if (item.nack)
                    begin
                        if (dir_reg != MODE_READ)
                        begin
                            phase_next    = PH_STOP;
                            res.bus_cmd   = CMD_STOP;
                            res.nack_seen = 1'b1;
                        end
                    end
                    else if (phase_next == PH_DATA)
                    begin
                        if (dir_reg != MODE_READ)
                        begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = buf_rd_data;
                            rd_ptr_next  = ptr_inc(rd_ptr_reg);
                            remain_next  = remain_reg - 8'd1;
                        end
                        else
                        begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = DUMMY_BYTE;
                        end
                        res.bus_cmd = CMD_DATA;
                    end
                end
            end
            FN_RX:
            begin
                if (busy_reg && dir_reg == MODE_READ)
                begin
                    res.rx_valid = 1'b1;
                    res.rx_byte  = item.data_byte;
                    res.rx_index = rx_cnt_reg;
                    rx_cnt_next  = rx_cnt_reg + 8'd1;
                    if (remain_reg != 8'd0)
                    begin
                        remain_next = remain_reg - 8'd1;
                    end
                end
            end
            default: ;
        endcase

        res.busy_res = busy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_ADDR;
            dir_reg    <= MODE_READ;
            remain_reg <= '0;
            pend_reg   <= '0;
            target_reg <= '0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            rx_cnt_reg <= '0;
            busy_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            dir_reg    <= dir_next;
            remain_reg <= remain_next;
            pend_reg   <= pend_next;
            target_reg <= target_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            rx_cnt_reg <= rx_cnt_next;
            busy_reg   <= busy_next;
        end
    end

    // prefetch the entry the read pointer will point at after this edge
    always_comb
    begin
        buf_req.we    = accept && (item.func == FN_LOAD) && !busy_reg;
        buf_req.waddr = wr_ptr_reg;
        buf_req.wdata = item.data_byte;
        buf_req.raddr = accept ? rd_ptr_next : rd_ptr_reg;
    end

    assign result = res;

    a_load_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        buf_req.we |-> !busy_reg)
        else $error("buffer written during a transaction");

    a_start_clears_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.func == FN_START && !busy_reg && mode_ok
        |=> busy_reg && rd_ptr_reg == '0 && wr_ptr_reg == '0 && rx_cnt_reg == '0)
        else $error("start did not reset pointers");

    a_release_idles: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.done_res |=> !busy_reg && phase_reg == PH_ADDR)
        else $error("release left the sequencer busy");

endmodule

@@ sv/i2c_master_transaction_sequencer_unit.sv @@
// Top level of the I2C master transaction sequencer: event in, result out.
// Depends on i2cmts_pkg, i2cmts_in_if, i2cmts_out_if, i2cmts_core, i2cmts_buf.
//
//  channel   dir   beat payload  contents
//  in_ch     in    in_item_t     one bus event (load, start, cond done, ack, rx byte)
//  out_ch    out   out_item_t    one result per event
//
// Each event beat is decided in the cycle it is accepted; its result appears in the
// output register on the next cycle. One event per cycle is sustained while out_ch
// takes results; the output register stalls the input only when it holds an untaken
// beat. Buffer data for transmit comes from a registered read that is prefetched at
// the read pointer. rst_n clears all control state; the buffer is not cleared.
module i2c_master_transaction_sequencer_unit (
    input  logic         clk,
    input  logic         rst_n,
    i2cmts_in_if.sink    in_ch,
    i2cmts_out_if.source out_ch
);
    import i2cmts_pkg::*;

    logic      accept;
    buf_req_t  buf_req;
    logic [7:0] buf_rd_data;
    out_item_t result;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    i2cmts_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (in_ch.item),
        .buf_rd_data (buf_rd_data),
        .buf_req     (buf_req),
        .result      (result)
    );

    i2cmts_buf u_buf (
        .clk     (clk),
        .req     (buf_req),
        .rd_data (buf_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg <= result;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.item  = out_item_reg;

    a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_ch.valid)
        else $error("accepted event produced no result");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.item.done_res |-> !out_ch.item.busy_res
        && out_ch.item.bus_cmd == CMD_RELEASE)
        else $error("done result still busy");

    a_nack_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.item.nack_seen |-> out_ch.item.bus_cmd == CMD_STOP)
        else $error("nack without stop");

endmodule

@@ tb/sv/tb_i2c_master_transaction_sequencer_unit.sv @@
// Self-checking testbench for the I2C master transaction sequencer unit.
// Needs i2cmts_pkg, i2cmts_in_if, i2cmts_out_if and the block's RTL; drives bus events,
// predicts each response in a scoreboard class and compares every result beat.
module tb_i2c_master_transaction_sequencer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cmts_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 820;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int STALL_LIMIT    = 2000;
    localparam int MAX_REPORTS    = 10;

    // events outside the defined set, and a transfer mode the block rejects
    localparam logic [2:0] FN_RSVD5 = 3'd5;
    localparam logic [2:0] FN_RSVD6 = 3'd6;
    localparam logic [2:0] FN_RSVD7 = 3'd7;
    localparam logic [1:0] MODE_BAD = 2'd3;

    typedef enum logic [1:0] {PH_ADDR, PH_STOP, PH_RESTART, PH_DATA} seq_phase_t;

    class seq_scoreboard;
        seq_phase_t phase;
        logic [1:0] mode;
        logic [7:0] remaining;
        logic [7:0] reads_after_restart;
        logic [7:0] target;
        logic [7:0] rx_cnt;
        buf_ptr_t   rd_ptr;
        buf_ptr_t   wr_ptr;
        logic       busy;
        logic [7:0] tx_buf [BUFFER_DEPTH];
        out_item_t  expected_results [$];
        int         errors;
        int         checked;
        int         starts [3];

        function new();
            phase = PH_ADDR;
            mode = MODE_READ;
            remaining = '0;
            reads_after_restart = '0;
            target = '0;
            rx_cnt = '0;
            rd_ptr = '0;
            wr_ptr = '0;
            busy = 1'b0;
            errors = 0;
            checked = 0;
            foreach (starts[k]) starts[k] = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Advance the sequencer state by one accepted event and queue its response.
        function void note_event(in_item_t ev);
            out_item_t r;
            r = '0;
            case (ev.func)
                FN_LOAD:
                begin
                    if (!busy)
                    begin
                        tx_buf[wr_ptr] = ev.data_byte;
                        wr_ptr = wr_ptr + 1'b1;
                    end
                end
                FN_START:
                begin
                    if (!busy && ev.xfer_mode <= MODE_REGREAD)
                    begin
                        starts[ev.xfer_mode]++;
                        mode = ev.xfer_mode;
                        rd_ptr = '0;
                        wr_ptr = '0;
                        rx_cnt = '0;
                        phase = PH_ADDR;
                        busy = 1'b1;
                        r.bus_cmd = CMD_START;
                        if (ev.xfer_mode == MODE_WRITE)
                        begin
                            target = ev.slave_addr;
                            remaining = ev.count;
                        end
                        else if (ev.xfer_mode == MODE_READ)
                        begin
                            target = ev.slave_addr | READ_BIT;
                            remaining = ev.count;
                            r.rx_irq_ctl = RX_DISABLE;
                        end
                        else
                        begin
                            target = ev.slave_addr;
                            remaining = 8'd1;
                            reads_after_restart = ev.read_count;
                            r.rx_irq_ctl = RX_DISABLE;
                        end
                    end
                end
                FN_COND:
                begin
                    if (busy)
                    begin
                        case (phase)
                            PH_ADDR:
                            begin
                                r.ack_ctl = ACK_NACK;
                                r.tx_valid = 1'b1;
                                r.tx_byte = target;
                                r.bus_cmd = CMD_DATA;
                            end
                            PH_STOP:
                            begin
                                phase = PH_ADDR;
                                busy = 1'b0;
                                r.bus_cmd = CMD_RELEASE;
                                r.done_res = 1'b1;
                            end
                            PH_RESTART:
                            begin
                                remaining = reads_after_restart;
                                rx_cnt = '0;
                                mode = MODE_READ;
                                phase = PH_ADDR;
                                r.ack_ctl = ACK_NACK;
                                r.tx_valid = 1'b1;
                                r.tx_byte = target | READ_BIT;
                                r.bus_cmd = CMD_DATA;
                            end
                            default: ;
                        endcase
                    end
                end
                FN_ACK:
                begin
                    if (busy)
                    begin
                        if (remaining <= 8'd1)
                        begin
                            if (remaining == 8'd0 && mode != MODE_READ)
                            begin
                                phase = (mode == MODE_WRITE) ? PH_STOP : PH_RESTART;
                                r.bus_cmd = (mode == MODE_WRITE) ? CMD_STOP : CMD_RESTART;
                            end
                            else if (mode == MODE_READ)
                            begin
                                if (remaining != 8'd0)
                                begin
                                    r.ack_ctl = ACK_NACK;
                                end
                                else
                                begin
                                    r.rx_irq_ctl = RX_DISABLE;
                                    phase = PH_STOP;
                                    r.bus_cmd = CMD_STOP;
                                end
                            end
                        end
                        if (!ev.nack && (phase == PH_ADDR || phase == PH_DATA))
                        begin
                            r.tx_valid = 1'b1;
                            r.bus_cmd = CMD_DATA;
                            if (mode != MODE_READ)
                            begin
                                r.tx_byte = tx_buf[rd_ptr];
                                rd_ptr = rd_ptr + 1'b1;
                                remaining = remaining - 8'd1;
                            end
                            else
                            begin
                                r.tx_byte = DUMMY_BYTE;
                                // the first data slot after the address arms the receiver
                                if (phase == PH_ADDR)
                                begin
                                    if (remaining >= 8'd2) r.ack_ctl = ACK_SEND;
                                    r.rx_irq_ctl = RX_ENABLE;
                                end
                            end
                            phase = PH_DATA;
                        end
                        else if (ev.nack && mode != MODE_READ)
                        begin
                            phase = PH_STOP;
                            r.bus_cmd = CMD_STOP;
                            r.nack_seen = 1'b1;
                        end
                    end
                end
                FN_RX:
                begin
                    if (busy && mode == MODE_READ)
                    begin
                        r.rx_valid = 1'b1;
                        r.rx_byte = ev.data_byte;
                        r.rx_index = rx_cnt;
                        rx_cnt = rx_cnt + 8'd1;
                        if (remaining != 8'd0) remaining = remaining - 8'd1;
                    end
                end
                default: ;
            endcase
            r.busy_res = busy;
            expected_results.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            string     diff;
            checked++;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: result %h arrived with nothing expected", got);
                return;
            end
            want = expected_results.pop_front();
            diff = "";
            if (got.bus_cmd    !== want.bus_cmd)    diff = {diff, " bus_cmd"};
            if (got.tx_valid   !== want.tx_valid)   diff = {diff, " tx_valid"};
            if (got.tx_byte    !== want.tx_byte)    diff = {diff, " tx_byte"};
            if (got.ack_ctl    !== want.ack_ctl)    diff = {diff, " ack_ctl"};
            if (got.rx_irq_ctl !== want.rx_irq_ctl) diff = {diff, " rx_irq_ctl"};
            if (got.rx_valid   !== want.rx_valid)   diff = {diff, " rx_valid"};
            if (got.rx_byte    !== want.rx_byte)    diff = {diff, " rx_byte"};
            if (got.rx_index   !== want.rx_index)   diff = {diff, " rx_index"};
            if (got.done_res   !== want.done_res)   diff = {diff, " done_res"};
            if (got.nack_seen  !== want.nack_seen)  diff = {diff, " nack_seen"};
            if (got.busy_res   !== want.busy_res)   diff = {diff, " busy_res"};
            if (diff != "")
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: result %0d differs in%s: expected %h, got %h",
                             checked, diff, want, got);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    i2cmts_in_if  in_ch ();
    i2cmts_out_if out_ch ();

    i2c_master_transaction_sequencer_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    seq_scoreboard sb;
    int   items_sent = 0;
    int   burst_left = 1;
    int   stuck = 0;
    logic holdoff_req = 1'b0;

    always #CLK_HALF clk = ~clk;

    function automatic in_item_t rand_event();
        in_item_t r;
        r.func       = 3'($urandom_range(0, 7));
        r.slave_addr = 8'($urandom);
        r.xfer_mode  = 2'($urandom_range(0, 3));
        r.count      = 8'($urandom);
        r.read_count = 8'($urandom);
        r.data_byte  = 8'($urandom);
        r.nack       = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic in_item_t make_event(logic [2:0] fn, logic [7:0] addr, logic [1:0] md,
                                            logic [7:0] cnt, logic [7:0] rcnt,
                                            logic [7:0] data, logic nk);
        in_item_t r;
        r.func       = fn;
        r.slave_addr = addr;
        r.xfer_mode  = md;
        r.count      = cnt;
        r.read_count = rcnt;
        r.data_byte  = data;
        r.nack       = nk;
        return r;
    endfunction

    // Mostly short transfers, now and then a longer one.
    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return 8'($urandom_range(0, 5));
        if (r < 97) return 8'($urandom_range(6, 30));
        return 8'($urandom_range(31, 120));
    endfunction

    // Offer one beat and hold it until taken; close a burst with a random gap.
    task automatic send_event(input in_item_t it);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.item  <= it;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_event(it);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Load, start, then follow the bus through the transfer with some noise mixed in.
    task automatic run_transaction();
        in_item_t   it;
        logic [1:0] md;
        logic [2:0] last_fn;
        int         nload;
        int         steps;
        int         cap;
        it = rand_event();
        md = ($urandom_range(0, 19) == 0) ? MODE_BAD : 2'($urandom_range(0, 2));
        it.count = pick_len();
        it.read_count = pick_len();
        if (md == MODE_REGREAD)
            nload = $urandom_range(1, 2);
        else if (md == MODE_WRITE)
            nload = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : int'(it.count);
        else
            nload = $urandom_range(0, 1);
        repeat (nload) send_event(make_event(FN_LOAD, 8'($urandom), 2'($urandom), 8'($urandom),
                                             8'($urandom), 8'($urandom), 1'($urandom)));
        it.func = FN_START;
        it.xfer_mode = md;
        send_event(it);
        last_fn = FN_START;
        cap = 4 * (int'(it.count) + int'(it.read_count)) + 40;
        steps = 0;
        while (sb.busy && steps < cap)
        begin
            it = rand_event();
            if ($urandom_range(0, 9) != 0)
            begin
                it.nack = ($urandom_range(0, 19) == 0);
                case (sb.phase)
                    PH_STOP, PH_RESTART: it.func = FN_COND;
                    PH_ADDR: it.func = (last_fn == FN_COND) ? FN_ACK : FN_COND;
                    default: it.func = (sb.mode == MODE_READ && last_fn != FN_RX) ? FN_RX
                                                                                  : FN_ACK;
                endcase
            end
            send_event(it);
            last_fn = it.func;
            steps++;
        end
    endtask

    initial
    begin : stimulus
        in_item_t it;
        int       target_items;
        bit       drained;
        bit       held_off;
        sb = new();
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.item = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // undefined events and stray bus events while idle, bad mode on start, loads while idle
        send_event(make_event(FN_RSVD5, 8'hFF, MODE_BAD, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        send_event(make_event(FN_RSVD6, 8'h00, MODE_READ, 8'h00, 8'h00, 8'h00, 1'b0));
        send_event(make_event(FN_RSVD7, 8'h5A, MODE_WRITE, 8'hA5, 8'h5A, 8'hC3, 1'b1));
        send_event(make_event(FN_COND, 8'hFF, MODE_BAD, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        send_event(make_event(FN_ACK, 8'h00, MODE_READ, 8'h00, 8'h00, 8'h00, 1'b0));
        send_event(make_event(FN_RX, 8'h00, MODE_READ, 8'h00, 8'h00, 8'h3C, 1'b0));
        send_event(make_event(FN_START, 8'hA2, MODE_BAD, 8'h04, 8'h02, 8'h00, 1'b0));
        send_event(make_event(FN_LOAD, 8'h00, MODE_READ, 8'h00, 8'h00, 8'h00, 1'b0));
        send_event(make_event(FN_LOAD, 8'h00, MODE_READ, 8'h00, 8'h00, 8'hFF, 1'b0));
        send_event(make_event(FN_LOAD, 8'h00, MODE_READ, 8'h00, 8'h00, 8'hA5, 1'b0));
        // long write cut short by a NACK; loads and starts while busy are dropped
        send_event(make_event(FN_START, 8'hFE, MODE_WRITE, 8'hFF, 8'hFF, 8'h00, 1'b0));
        send_event(make_event(FN_LOAD, 8'h00, MODE_READ, 8'h00, 8'h00, 8'h5A, 1'b0));
        send_event(make_event(FN_START, 8'h12, MODE_READ, 8'h03, 8'h00, 8'h00, 1'b0));
        send_event(make_event(FN_COND, 8'h00, MODE_READ, 8'h00, 8'h00, 8'h00, 1'b0));
        send_event(make_event(FN_ACK, 8'h00, MODE_READ, 8'h00, 8'h00, 8'h00, 1'b0));
        send_event(make_event(FN_ACK, 8'h00, MODE_READ, 8'h00, 8'h00, 8'h00, 1'b0));
        send_event(make_event(FN_COND, 8'h00, MODE_READ, 8'h00, 8'h00, 8'h00, 1'b0));
        send_event(make_event(FN_ACK, 8'h00, MODE_READ, 8'h00, 8'h00, 8'h00, 1'b1));
        send_event(make_event(FN_COND, 8'h00, MODE_READ, 8'h00, 8'h00, 8'h00, 1'b0));
        // empty read: a received byte must not take the remaining count below zero
        send_event(make_event(FN_START, 8'h00, MODE_READ, 8'h00, 8'h00, 8'h00, 1'b0));
        send_event(make_event(FN_RX, 8'h00, MODE_READ, 8'h00, 8'h00, 8'h81, 1'b0));
        send_event(make_event(FN_COND, 8'h00, MODE_READ, 8'h00, 8'h00, 8'h00, 1'b0));
        send_event(make_event(FN_ACK, 8'h00, MODE_READ, 8'h00, 8'h00, 8'h00, 1'b0));
        send_event(make_event(FN_COND, 8'h00, MODE_READ, 8'h00, 8'h00, 8'h00, 1'b0));

        // Fill every buffer entry and wrap the load pointer; after this no transmit
        // can pick up an entry that was never written.
        for (int k = 0; k < BUFFER_DEPTH + 2; k++)
        begin
            it = rand_event();
            it.func = FN_LOAD;
            send_event(it);
        end

        target_items = items_sent + RANDOM_ITEMS;
        drained = 1'b0;
        held_off = 1'b0;
        while (items_sent < target_items)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                it = rand_event();
                case ($urandom_range(0, 6))
                    0: it.func = FN_LOAD;
                    1: it.func = FN_COND;
                    2: it.func = FN_ACK;
                    3: it.func = FN_RX;
                    4: it.func = FN_RSVD5;
                    5: it.func = FN_RSVD6;
                    default: it.func = FN_RSVD7;
                endcase
                send_event(it);
            end
            run_transaction();
            if (items_sent > target_items - RANDOM_ITEMS / 2 && !held_off)
            begin
                held_off = 1'b1;
                holdoff_req = 1'b1;
            end
            if (!drained && items_sent > target_items - RANDOM_ITEMS / 4)
            begin
                drained = 1'b1;
                drain_results();
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        $display("Drove %0d events: %0d write, %0d read, %0d register-read transfers started",
                 items_sent, sb.starts[MODE_WRITE], sb.starts[MODE_READ],
                 sb.starts[MODE_REGREAD]);
        $display("Checked %0d result beats, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Receiver: rotate between always-ready, random and periodic stall patterns,
    // and hold off for a long stretch once on request.
    initial
    begin : receiver
        int cyc;
        int hold_left;
        cyc = 0;
        hold_left = 0;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (holdoff_req && hold_left == 0)
            begin
                holdoff_req = 1'b0;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                case ((cyc / 300) % 4)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 99) < 70);
                    2: out_ch.ready <= ((cyc % 5) != 0);
                    default: out_ch.ready <= ($urandom_range(0, 99) < 30);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.item);
    end

    always @(posedge clk)
    begin : watchdog
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            stuck = 0;
        end
        else
        begin
            stuck++;
            if (stuck >= STALL_LIMIT)
            begin
                $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
